### rtl/tbv_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tbv_pkg
// Types, constants and the step microprogram of the two-body Verlet stepper.
// ----------------------------------------------------------------------------
package tbv_pkg;

    localparam int FRAC_BITS = 32;
    localparam int WORD_BITS = 48;
    localparam int TIME_BITS = WORD_BITS - 1;
    localparam int STEP_BITS = 33;
    localparam int MASS_BITS = 47;

    localparam int RF_DEPTH  = 32;
    localparam int RF_AW     = 5;
    localparam int PC_BITS   = 7;
    localparam int FILL_BITS = 4;

    localparam int HALF_BITS = WORD_BITS / 2;
    localparam int PROD_BITS = 2 * WORD_BITS;
    localparam int QW_BITS   = PROD_BITS - FRAC_BITS;
    localparam int SQRT_BITS = (WORD_BITS + FRAC_BITS) / 2;
    localparam int RAD_BITS  = 2 * SQRT_BITS;
    localparam int NUM_BITS  = MASS_BITS + FRAC_BITS;
    localparam int CNT_BITS  = $clog2(NUM_BITS);

    typedef logic signed [WORD_BITS-1:0] word_t;

    localparam word_t WMAX  = {1'b0, {(WORD_BITS-1){1'b1}}};
    localparam word_t WMIN  = {1'b1, {(WORD_BITS-1){1'b0}}};
    localparam word_t ONE_W = word_t'(1) <<< FRAC_BITS;

    localparam logic [STEP_BITS-1:0] STEP_RESET = STEP_BITS'(4294967);
    localparam logic [MASS_BITS-1:0] MASS_ONE_RESET = MASS_BITS'(100) << FRAC_BITS;
    localparam logic [MASS_BITS-1:0] MASS_TWO_RESET = MASS_BITS'(10) << FRAC_BITS;
    localparam logic [MASS_BITS-1:0] GRAV_RESET     = MASS_BITS'(1) << FRAC_BITS;

    typedef enum logic [1:0] {
        CFG_STEP_SIZE,
        CFG_MASS_ONE,
        CFG_MASS_TWO,
        CFG_GRAV_CONST
    } cfg_idx_t;

    typedef struct packed {
        logic  mode;
        word_t load_pos1_x;
        word_t load_pos1_y;
        word_t load_pos2_x;
        word_t load_pos2_y;
        word_t load_vel1_x;
        word_t load_vel1_y;
        word_t load_vel2_x;
        word_t load_vel2_y;
    } item_t;

    typedef struct packed {
        logic [TIME_BITS-1:0] elapsed_time;
        word_t                out_pos1_x;
        word_t                out_pos1_y;
        word_t                out_pos2_x;
        word_t                out_pos2_y;
        logic                 saturated;
    } result_t;

    typedef enum logic [RF_AW-1:0] {
        R_P1X, R_P1Y, R_P2X, R_P2Y, R_V1X, R_V1Y, R_V2X, R_V2Y,
        R_TIME, R_H, R_M1, R_M2, R_G, R_HH1, R_HH2, R_HM1,
        R_HM2, R_DX, R_DY, R_K0, R_A0X, R_A0Y, R_NP1X, R_NP1Y,
        R_NP2X, R_NP2Y, R_K1, R_T1, R_T2, R_RSQ, R_R, R_T3
    } reg_t;

    typedef enum logic [3:0] {
        OP_MOV, OP_ADD, OP_SUB, OP_MUL, OP_MULH, OP_SQRT, OP_DIV,
        OP_CFG, OP_EMIT, OP_END
    } op_t;

    typedef struct packed {
        op_t  op;
        reg_t a;
        reg_t b;
        reg_t dst;
    } uop_t;

    typedef struct packed {
        logic start;
        op_t  op;
    } alu_req_t;

    typedef struct packed {
        logic  done;
        logic  clip;
        word_t result;
    } alu_rsp_t;

    typedef enum logic [2:0] {
        A_IDLE, A_MUL, A_MFIN, A_SQRT, A_DIV, A_DONE
    } alu_state_t;

    typedef enum logic [2:0] {
        S_INIT, S_IDLE, S_LOAD, S_FETCH, S_ISSUE, S_WAIT, S_OUT
    } top_state_t;

    function automatic word_t init_value(input reg_t r);
        word_t v;
        case (r)
            R_P2X, R_P2Y: v = ONE_W + ONE_W;
            R_V1X, R_V1Y: v = ONE_W;
            R_V2X:        v = -ONE_W;
            R_V2Y:        v = -(word_t'(5) <<< FRAC_BITS);
            default:      v = '0;
        endcase
        return v;
    endfunction

    function automatic uop_t mk(input op_t op, input reg_t a, input reg_t b, input reg_t d);
        uop_t u;
        u.op  = op;
        u.a   = a;
        u.b   = b;
        u.dst = d;
        return u;
    endfunction

    function automatic uop_t ucode(input logic [PC_BITS-1:0] pc);
        uop_t u;
        case (pc)
            7'd0:  u = mk(OP_CFG,  R_H,    R_H,    R_H);
            7'd1:  u = mk(OP_CFG,  R_M1,   R_M1,   R_M1);
            7'd2:  u = mk(OP_CFG,  R_M2,   R_M2,   R_M2);
            7'd3:  u = mk(OP_CFG,  R_G,    R_G,    R_G);
            7'd4:  u = mk(OP_MUL,  R_H,    R_H,    R_T1);
            7'd5:  u = mk(OP_MUL,  R_T1,   R_M1,   R_HH1);
            7'd6:  u = mk(OP_MUL,  R_T1,   R_M2,   R_HH2);
            7'd7:  u = mk(OP_MUL,  R_H,    R_M1,   R_HM1);
            7'd8:  u = mk(OP_MUL,  R_H,    R_M2,   R_HM2);
            7'd9:  u = mk(OP_SUB,  R_P2X,  R_P1X,  R_DX);
            7'd10: u = mk(OP_SUB,  R_P2Y,  R_P1Y,  R_DY);
            7'd11: u = mk(OP_MUL,  R_DX,   R_DX,   R_T1);
            7'd12: u = mk(OP_MUL,  R_DY,   R_DY,   R_T2);
            7'd13: u = mk(OP_ADD,  R_T1,   R_T2,   R_RSQ);
            7'd14: u = mk(OP_SQRT, R_RSQ,  R_RSQ,  R_R);
            7'd15: u = mk(OP_MUL,  R_RSQ,  R_R,    R_T3);
            7'd16: u = mk(OP_DIV,  R_G,    R_T3,   R_K0);
            7'd17: u = mk(OP_MUL,  R_K0,   R_DX,   R_A0X);
            7'd18: u = mk(OP_MUL,  R_H,    R_V1X,  R_T1);
            7'd19: u = mk(OP_ADD,  R_P1X,  R_T1,   R_T1);
            7'd20: u = mk(OP_MULH, R_HH2,  R_A0X,  R_T2);
            7'd21: u = mk(OP_ADD,  R_T1,   R_T2,   R_NP1X);
            7'd22: u = mk(OP_MUL,  R_H,    R_V2X,  R_T1);
            7'd23: u = mk(OP_ADD,  R_P2X,  R_T1,   R_T1);
            7'd24: u = mk(OP_MULH, R_HH1,  R_A0X,  R_T2);
            7'd25: u = mk(OP_SUB,  R_T1,   R_T2,   R_NP2X);
            7'd26: u = mk(OP_MUL,  R_K0,   R_DY,   R_A0Y);
            7'd27: u = mk(OP_MUL,  R_H,    R_V1Y,  R_T1);
            7'd28: u = mk(OP_ADD,  R_P1Y,  R_T1,   R_T1);
            7'd29: u = mk(OP_MULH, R_HH2,  R_A0Y,  R_T2);
            7'd30: u = mk(OP_ADD,  R_T1,   R_T2,   R_NP1Y);
            7'd31: u = mk(OP_MUL,  R_H,    R_V2Y,  R_T1);
            7'd32: u = mk(OP_ADD,  R_P2Y,  R_T1,   R_T1);
            7'd33: u = mk(OP_MULH, R_HH1,  R_A0Y,  R_T2);
            7'd34: u = mk(OP_SUB,  R_T1,   R_T2,   R_NP2Y);
            7'd35: u = mk(OP_SUB,  R_NP2X, R_NP1X, R_DX);
            7'd36: u = mk(OP_SUB,  R_NP2Y, R_NP1Y, R_DY);
            7'd37: u = mk(OP_MUL,  R_DX,   R_DX,   R_T1);
            7'd38: u = mk(OP_MUL,  R_DY,   R_DY,   R_T2);
            7'd39: u = mk(OP_ADD,  R_T1,   R_T2,   R_RSQ);
            7'd40: u = mk(OP_SQRT, R_RSQ,  R_RSQ,  R_R);
            7'd41: u = mk(OP_MUL,  R_RSQ,  R_R,    R_T3);
            7'd42: u = mk(OP_DIV,  R_G,    R_T3,   R_K1);
            7'd43: u = mk(OP_EMIT, R_TIME, R_TIME, R_TIME);
            7'd44: u = mk(OP_EMIT, R_P1X,  R_P1X,  R_P1X);
            7'd45: u = mk(OP_EMIT, R_P1Y,  R_P1Y,  R_P1Y);
            7'd46: u = mk(OP_EMIT, R_P2X,  R_P2X,  R_P2X);
            7'd47: u = mk(OP_EMIT, R_P2Y,  R_P2Y,  R_P2Y);
            7'd48: u = mk(OP_MUL,  R_K1,   R_DX,   R_T1);
            7'd49: u = mk(OP_ADD,  R_T1,   R_A0X,  R_T1);
            7'd50: u = mk(OP_MULH, R_HM2,  R_T1,   R_T2);
            7'd51: u = mk(OP_ADD,  R_V1X,  R_T2,   R_V1X);
            7'd52: u = mk(OP_MULH, R_HM1,  R_T1,   R_T2);
            7'd53: u = mk(OP_SUB,  R_V2X,  R_T2,   R_V2X);
            7'd54: u = mk(OP_MOV,  R_NP1X, R_NP1X, R_P1X);
            7'd55: u = mk(OP_MOV,  R_NP2X, R_NP2X, R_P2X);
            7'd56: u = mk(OP_MUL,  R_K1,   R_DY,   R_T1);
            7'd57: u = mk(OP_ADD,  R_T1,   R_A0Y,  R_T1);
            7'd58: u = mk(OP_MULH, R_HM2,  R_T1,   R_T2);
            7'd59: u = mk(OP_ADD,  R_V1Y,  R_T2,   R_V1Y);
            7'd60: u = mk(OP_MULH, R_HM1,  R_T1,   R_T2);
            7'd61: u = mk(OP_SUB,  R_V2Y,  R_T2,   R_V2Y);
            7'd62: u = mk(OP_MOV,  R_NP1Y, R_NP1Y, R_P1Y);
            7'd63: u = mk(OP_MOV,  R_NP2Y, R_NP2Y, R_P2Y);
            7'd64: u = mk(OP_ADD,  R_TIME, R_H,    R_TIME);
            default: u = mk(OP_END, R_P1X, R_P1X, R_P1X);
        endcase
        return u;
    endfunction

endpackage

### rtl/tbv_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tbv_ram
// Generic RAM, one write port and two registered read ports.
// ----------------------------------------------------------------------------
module tbv_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr_a,
    input  logic [$clog2(DEPTH)-1:0] raddr_b,
    output logic [WIDTH-1:0]         rdata_a,
    output logic [WIDTH-1:0]         rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_a <= mem[raddr_a];
        rdata_b <= mem[raddr_b];
    end

endmodule

### rtl/tbv_alu.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tbv_alu
// Shared fixed-point unit: saturating add/sub, rounded multiply over four
// partial products, bit-serial square root and bit-serial division.
// ----------------------------------------------------------------------------
module tbv_alu (
    input  logic             clk,
    input  logic             rst_n,
    input  tbv_pkg::alu_req_t req,
    input  tbv_pkg::word_t   a,
    input  tbv_pkg::word_t   b,
    output tbv_pkg::alu_rsp_t rsp
);
    import tbv_pkg::*;

    alu_state_t state_reg, state_next;
    op_t        op_reg, op_next;
    logic [CNT_BITS-1:0]  cnt_reg, cnt_next;
    logic [WORD_BITS-1:0] ma_reg, ma_next, mb_reg, mb_next;
    logic                 neg_reg, neg_next;
    logic [PROD_BITS-1:0] acc_reg, acc_next;
    word_t                res_reg, res_next;
    logic                 clip_reg, clip_next;
    logic [RAD_BITS-1:0]  rad_reg, rad_next;
    logic [SQRT_BITS:0]   rem_reg, rem_next;
    logic [SQRT_BITS-1:0] root_reg, root_next;
    logic [NUM_BITS-1:0]  num_reg, num_next, q_reg, q_next;
    logic [WORD_BITS-1:0] drem_reg, drem_next, dvs_reg, dvs_next;

    logic [WORD_BITS:0]     sum_add, sum_sub;
    logic [WORD_BITS-1:0]   pp;
    logic [PROD_BITS-1:0]   pp_shift, rounded;
    logic [QW_BITS-1:0]     qwide, lim_neg, lim;
    logic [WORD_BITS-1:0]   mag, val, halfsum;
    logic [SQRT_BITS+2:0]   rem_t, trial, rem_sub;
    logic [SQRT_BITS-1:0]   root_new;
    logic                   sq_ge, dv_ge, over;
    logic [WORD_BITS:0]     drem_t, dvs_ext, drem_sub;
    logic [NUM_BITS-1:0]    q_new;

    always_comb
    begin
        sum_add  = {a[WORD_BITS-1], a} + {b[WORD_BITS-1], b};
        sum_sub  = {a[WORD_BITS-1], a} - {b[WORD_BITS-1], b};
        pp       = ma_reg[cnt_reg[1]*HALF_BITS +: HALF_BITS]
                 * mb_reg[cnt_reg[0]*HALF_BITS +: HALF_BITS];
        case ({1'b0, cnt_reg[1]} + {1'b0, cnt_reg[0]})
            2'd1:    pp_shift = PROD_BITS'(pp) << HALF_BITS;
            2'd2:    pp_shift = PROD_BITS'(pp) << WORD_BITS;
            default: pp_shift = PROD_BITS'(pp);
        endcase
        rounded  = acc_reg + (PROD_BITS'(1) << (FRAC_BITS - 1));
        qwide    = rounded[PROD_BITS-1:FRAC_BITS];
        lim_neg  = QW_BITS'(1) << (WORD_BITS - 1);
        lim      = neg_reg ? lim_neg : lim_neg - QW_BITS'(1);
        over     = qwide > lim;
        mag      = over ? lim[WORD_BITS-1:0] : qwide[WORD_BITS-1:0];
        val      = neg_reg ? WORD_BITS'(0) - mag : mag;
        halfsum  = val + {{(WORD_BITS-1){1'b0}}, val[WORD_BITS-1]};

        rem_t    = {rem_reg, rad_reg[RAD_BITS-1 -: 2]};
        trial    = {1'b0, root_reg, 2'b01};
        sq_ge    = rem_t >= trial;
        rem_sub  = rem_t - trial;
        root_new = {root_reg[SQRT_BITS-2:0], sq_ge};

        drem_t   = {drem_reg, num_reg[NUM_BITS-1]};
        dvs_ext  = {1'b0, dvs_reg};
        dv_ge    = drem_t >= dvs_ext;
        drem_sub = drem_t - dvs_ext;
        q_new    = {q_reg[NUM_BITS-2:0], dv_ge};
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            A_IDLE:
            begin
                if (req.start)
                begin
                    case (req.op)
                        OP_MUL, OP_MULH: state_next = A_MUL;
                        OP_SQRT:         state_next = A_SQRT;
                        OP_DIV:
                        begin
                            if (b[WORD_BITS-1] || b == '0)
                                state_next = A_DONE;
                            else
                                state_next = A_DIV;
                        end
                        default:         state_next = A_DONE;
                    endcase
                end
            end
            A_MUL:  if (cnt_reg[1:0] == 2'd3) state_next = A_MFIN;
            A_MFIN: state_next = A_DONE;
            A_SQRT: if (cnt_reg == CNT_BITS'(SQRT_BITS - 1)) state_next = A_DONE;
            A_DIV:  if (cnt_reg == CNT_BITS'(NUM_BITS - 1)) state_next = A_DONE;
            A_DONE: state_next = A_IDLE;
            default: state_next = A_IDLE;
        endcase
    end

    always_comb
    begin
        op_next   = op_reg;
        cnt_next  = cnt_reg + CNT_BITS'(1);
        ma_next   = ma_reg;
        mb_next   = mb_reg;
        neg_next  = neg_reg;
        acc_next  = acc_reg;
        res_next  = res_reg;
        clip_next = clip_reg;
        rad_next  = rad_reg;
        rem_next  = rem_reg;
        root_next = root_reg;
        num_next  = num_reg;
        q_next    = q_reg;
        drem_next = drem_reg;
        dvs_next  = dvs_reg;
        case (state_reg)
            A_IDLE:
            begin
                op_next   = req.op;
                cnt_next  = '0;
                clip_next = 1'b0;
                ma_next   = a[WORD_BITS-1] ? WORD_BITS'(0) - a : a;
                mb_next   = b[WORD_BITS-1] ? WORD_BITS'(0) - b : b;
                neg_next  = a[WORD_BITS-1] ^ b[WORD_BITS-1];
                acc_next  = '0;
                rad_next  = RAD_BITS'({a[WORD_BITS-2:0], {FRAC_BITS{1'b0}}});
                rem_next  = '0;
                root_next = '0;
                num_next  = {a[MASS_BITS-1:0], {FRAC_BITS{1'b0}}};
                q_next    = '0;
                drem_next = '0;
                dvs_next  = b;
                case (req.op)
                    OP_MOV: res_next = a;
                    OP_ADD:
                    begin
                        res_next  = sum_add[WORD_BITS-1:0];
                        if (sum_add[WORD_BITS] != sum_add[WORD_BITS-1])
                        begin
                            clip_next = 1'b1;
                            res_next  = sum_add[WORD_BITS] ? WMIN : WMAX;
                        end
                    end
                    OP_SUB:
                    begin
                        res_next  = sum_sub[WORD_BITS-1:0];
                        if (sum_sub[WORD_BITS] != sum_sub[WORD_BITS-1])
                        begin
                            clip_next = 1'b1;
                            res_next  = sum_sub[WORD_BITS] ? WMIN : WMAX;
                        end
                    end
                    OP_DIV:
                    begin
                        res_next  = WMAX;
                        clip_next = 1'b1;
                    end
                    default: res_next = res_reg;
                endcase
            end
            A_MUL: acc_next = acc_reg + pp_shift;
            A_MFIN:
            begin
                clip_next = over;
                if (op_reg == OP_MULH)
                    res_next = {halfsum[WORD_BITS-1], halfsum[WORD_BITS-1:1]};
                else
                    res_next = val;
            end
            A_SQRT:
            begin
                rad_next  = rad_reg << 2;
                rem_next  = sq_ge ? rem_sub[SQRT_BITS:0] : rem_t[SQRT_BITS:0];
                root_next = root_new;
                res_next  = WORD_BITS'(root_new);
            end
            A_DIV:
            begin
                num_next  = num_reg << 1;
                drem_next = dv_ge ? drem_sub[WORD_BITS-1:0] : drem_t[WORD_BITS-1:0];
                q_next    = q_new;
                if (|q_new[NUM_BITS-1:WORD_BITS-1])
                begin
                    res_next  = WMAX;
                    clip_next = 1'b1;
                end
                else
                begin
                    res_next  = {1'b0, q_new[WORD_BITS-2:0]};
                    clip_next = 1'b0;
                end
            end
            default: cnt_next = cnt_reg;
        endcase
    end

    always_comb
    begin
        rsp.done   = state_reg == A_DONE;
        rsp.clip   = clip_reg;
        rsp.result = res_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= A_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg   <= op_next;
        cnt_reg  <= cnt_next;
        ma_reg   <= ma_next;
        mb_reg   <= mb_next;
        neg_reg  <= neg_next;
        acc_reg  <= acc_next;
        res_reg  <= res_next;
        clip_reg <= clip_next;
        rad_reg  <= rad_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
        num_reg  <= num_next;
        q_reg    <= q_next;
        drem_reg <= drem_next;
        dvs_reg  <= dvs_next;
    end

endmodule

### rtl/two_body_verlet_step.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// two_body_verlet_step
// Planar two-body velocity Verlet stepper, Q16.32, one shared unit under a
// microprogram sequencer with a 32-entry register file.
// ----------------------------------------------------------------------------
// A tick runs 65 micro-ops from transfer to result, each fetched and issued;
// all but the configuration and emit ops then wait on the shared unit (add,
// multiply, square root, divide). A load writes positions and velocities.
// One item at a time; item_stall stays high until the result is transferred
// or the load is written. After reset, the start state goes into the register
// file with item_stall high; configuration writes are taken at any time.
module two_body_verlet_step (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                item_valid,
    output logic                                item_stall,
    input  tbv_pkg::item_t                      item,
    output logic                                result_valid,
    input  logic                                result_stall,
    output tbv_pkg::result_t                    result,
    input  logic                                cfg_wr,
    input  tbv_pkg::cfg_idx_t                   cfg_index,
    input  logic [tbv_pkg::MASS_BITS-1:0]       cfg_data
);
    import tbv_pkg::*;

    top_state_t state_reg, state_next;
    logic [PC_BITS-1:0]   pc_reg, pc_next;
    logic [FILL_BITS-1:0] fill_reg, fill_next;
    item_t                item_reg, item_next;
    result_t              res_reg, res_next;
    logic                 clip_reg, clip_next;
    logic [STEP_BITS-1:0] step_reg;
    logic [MASS_BITS-1:0] mass_one_reg, mass_two_reg, grav_reg;

    uop_t       uop;
    logic       accept;
    logic       rf_we;
    reg_t       rf_waddr;
    word_t      rf_wdata;
    word_t      rd_a, rd_b;
    alu_req_t   alu_req;
    alu_rsp_t   alu_rsp;
    reg_t       fill_addr;

    function automatic word_t load_word(input item_t it, input reg_t r);
        word_t v;
        case (r)
            R_P1X:   v = it.load_pos1_x;
            R_P1Y:   v = it.load_pos1_y;
            R_P2X:   v = it.load_pos2_x;
            R_P2Y:   v = it.load_pos2_y;
            R_V1X:   v = it.load_vel1_x;
            R_V1Y:   v = it.load_vel1_y;
            R_V2X:   v = it.load_vel2_x;
            R_V2Y:   v = it.load_vel2_y;
            default: v = '0;
        endcase
        return v;
    endfunction

    assign uop       = ucode(pc_reg);
    assign accept    = item_valid && state_reg == S_IDLE;
    assign fill_addr = reg_t'({1'b0, fill_reg});

    tbv_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (RF_DEPTH)
    ) u_rf (
        .clk     (clk),
        .we      (rf_we),
        .waddr   (rf_waddr),
        .wdata   (rf_wdata),
        .raddr_a (uop.a),
        .raddr_b (uop.b),
        .rdata_a (rd_a),
        .rdata_b (rd_b)
    );

    tbv_alu u_alu (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (alu_req),
        .a     (rd_a),
        .b     (rd_b),
        .rsp   (alu_rsp)
    );

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_INIT:  if (fill_addr == R_TIME) state_next = S_IDLE;
            S_IDLE:
            begin
                if (item_valid)
                    state_next = item.mode ? S_FETCH : S_LOAD;
            end
            S_LOAD:  if (fill_addr == R_TIME) state_next = S_IDLE;
            S_FETCH: state_next = S_ISSUE;
            S_ISSUE:
            begin
                case (uop.op)
                    OP_CFG, OP_EMIT: state_next = S_FETCH;
                    OP_END:          state_next = S_OUT;
                    default:         state_next = S_WAIT;
                endcase
            end
            S_WAIT:  if (alu_rsp.done) state_next = S_FETCH;
            S_OUT:   if (!result_stall) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        item_stall    = state_reg != S_IDLE;
        result_valid  = state_reg == S_OUT;
        result        = res_reg;
        alu_req.start = state_reg == S_ISSUE && uop.op != OP_CFG
                        && uop.op != OP_EMIT && uop.op != OP_END;
        alu_req.op    = uop.op;
        rf_we         = 1'b0;
        rf_waddr      = uop.dst;
        rf_wdata      = alu_rsp.result;
        case (state_reg)
            S_INIT:
            begin
                rf_we    = 1'b1;
                rf_waddr = fill_addr;
                rf_wdata = init_value(fill_addr);
            end
            S_LOAD:
            begin
                rf_we    = 1'b1;
                rf_waddr = fill_addr;
                rf_wdata = load_word(item_reg, fill_addr);
            end
            S_ISSUE:
            begin
                if (uop.op == OP_CFG)
                begin
                    rf_we = 1'b1;
                    case (uop.dst)
                        R_H:     rf_wdata = word_t'({1'b0, step_reg});
                        R_M1:    rf_wdata = {1'b0, mass_one_reg};
                        R_M2:    rf_wdata = {1'b0, mass_two_reg};
                        default: rf_wdata = {1'b0, grav_reg};
                    endcase
                end
            end
            S_WAIT:  rf_we = alu_rsp.done;
            default: rf_we = 1'b0;
        endcase
    end

    always_comb
    begin
        pc_next   = pc_reg;
        fill_next = fill_reg;
        item_next = accept ? item : item_reg;
        res_next  = res_reg;
        clip_next = clip_reg;
        case (state_reg)
            S_INIT, S_LOAD: fill_next = fill_reg + FILL_BITS'(1);
            S_IDLE:
            begin
                fill_next = '0;
                pc_next   = '0;
                clip_next = 1'b0;
            end
            S_ISSUE:
            begin
                case (uop.op)
                    OP_CFG:  pc_next = pc_reg + PC_BITS'(1);
                    OP_EMIT:
                    begin
                        pc_next = pc_reg + PC_BITS'(1);
                        case (uop.a)
                            R_TIME:  res_next.elapsed_time = rd_a[TIME_BITS-1:0];
                            R_P1X:   res_next.out_pos1_x   = rd_a;
                            R_P1Y:   res_next.out_pos1_y   = rd_a;
                            R_P2X:   res_next.out_pos2_x   = rd_a;
                            default: res_next.out_pos2_y   = rd_a;
                        endcase
                    end
                    OP_END:  res_next.saturated = clip_reg;
                    default: pc_next = pc_reg;
                endcase
            end
            S_WAIT:
            begin
                if (alu_rsp.done)
                begin
                    pc_next   = pc_reg + PC_BITS'(1);
                    clip_next = clip_reg | alu_rsp.clip;
                end
            end
            default: pc_next = pc_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_INIT;
            pc_reg       <= '0;
            fill_reg     <= '0;
            clip_reg     <= 1'b0;
            step_reg     <= STEP_RESET;
            mass_one_reg <= MASS_ONE_RESET;
            mass_two_reg <= MASS_TWO_RESET;
            grav_reg     <= GRAV_RESET;
        end
        else
        begin
            state_reg <= state_next;
            pc_reg    <= pc_next;
            fill_reg  <= fill_next;
            clip_reg  <= clip_next;
            if (cfg_wr)
            begin
                case (cfg_index)
                    CFG_STEP_SIZE:  step_reg     <= cfg_data[STEP_BITS-1:0];
                    CFG_MASS_ONE:   mass_one_reg <= cfg_data;
                    CFG_MASS_TWO:   mass_two_reg <= cfg_data;
                    CFG_GRAV_CONST: grav_reg     <= cfg_data;
                    default:        grav_reg     <= grav_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
        res_reg  <= res_next;
    end

endmodule
